// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; expects clk and rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define CLLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define CLLD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/clld_pkg.sv =====
// types, codes and sizes for the console line discipline
// no dependencies
package clld_pkg;

  localparam int LINE_CAPACITY = 256;
  localparam int QUEUE_DEPTH   = 1024;

  localparam int LA = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QF = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] KEY_INTR   = 8'h03;
  localparam logic [7:0] KEY_EOF    = 8'h04;
  localparam logic [7:0] KEY_BS     = 8'h08;
  localparam logic [7:0] KEY_NL     = 8'h0A;
  localparam logic [7:0] KEY_STOP   = 8'h1A;
  localparam logic [7:0] KEY_SPACE  = 8'd32;
  localparam logic [7:0] KEY_TILDE  = 8'd126;

  localparam logic [6:0] CHAR_NL    = 7'h0A;
  localparam logic [6:0] CHAR_BS    = 7'h08;
  localparam logic [6:0] CHAR_CARET = 7'h5E;
  localparam logic [6:0] CHAR_C     = 7'h43;
  localparam logic [6:0] CHAR_Z     = 7'h5A;

  typedef enum logic [1:0] {
    F_KEY   = 2'd0,
    F_READ  = 2'd1,
    F_SET   = 2'd2,
    F_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_ECHO   = 3'd0,
    K_BS     = 3'd1,
    K_SIGNAL = 3'd2,
    K_WAKE   = 3'd3,
    K_DATA   = 3'd4,
    K_EMPTY  = 3'd5,
    K_EOF    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_SIG,
    S_NL,
    S_COPY,
    S_RDW
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  char_out;
    logic        signal_code;
    logic [15:0] target_owner;
    logic        last;
  } result_t;

endpackage

// ===== design/console_line_discipline_top.sv =====
// console line discipline: canonical keyboard line editor with a ready ring
// depends on clld_pkg, clld_seq, clld_obuf
//
//   stream   direction  tvalid/tready  tdata                          tuser  tlast
//   s_axis   in         yes            key_code, new_owner            func   -
//   m_axis   out        yes            char_out, signal_code, target  kind   last
//
// set, clear and ignored keys send no words; echo, backspace, eof and read items send one
// a signal sends its words one per cycle while the output does not stall
// enter echoes a newline, copies the line store into the ready ring, then sends a wake word
// one item at a time; the next item is taken once its last word sits in the output register
// output stalls hold the sequencer; reset is synchronous, no memory clearing
module console_line_discipline_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // key_code[7:0], new_owner[23:8]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // char_out[6:0], signal_code[7], target_owner[23:8]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);

  logic              seq_valid, seq_ready;
  clld_pkg::result_t seq_word, buf_word;

  clld_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (clld_pkg::func_t'(s_axis_tuser)),
    .in_key    (s_axis_tdata[7:0]),
    .in_owner  (s_axis_tdata[23:8]),
    .out_valid (seq_valid),
    .out_ready (seq_ready),
    .out_word  (seq_word)
  );

  clld_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .in_word   (seq_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (buf_word)
  );

  assign m_axis_tdata = {buf_word.target_owner, buf_word.signal_code, buf_word.char_out};
  assign m_axis_tuser = buf_word.kind;
  assign m_axis_tlast = buf_word.last;

endmodule

// ===== design/clld_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module clld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/clld_seq.sv =====
// sequencer: state machine, line store and ready ring memories with their pointers
// depends on clld_pkg and clld_ram
module clld_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  clld_pkg::func_t      in_func,
  input  logic [7:0]           in_key,
  input  logic [15:0]          in_owner,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clld_pkg::result_t    out_word
);

  localparam int LA = clld_pkg::LA;
  localparam int QA = clld_pkg::QA;
  localparam int QF = clld_pkg::QF;

  clld_pkg::state_t state, state_next;
  logic [1:0]    step, step_next;
  logic [LA-1:0] idx, idx_next;
  logic          rd_pend, rd_pend_next;
  logic [LA-1:0] line_length, line_length_next;
  logic [QA-1:0] ring_head, ring_head_next;
  logic [QA-1:0] ring_tail, ring_tail_next;
  logic [QF-1:0] ring_fill, ring_fill_next;
  logic          end_of_input, end_of_input_next;
  logic [15:0]   owner_id, owner_id_next;
  clld_pkg::kind_t res_kind, res_kind_next;
  logic [6:0]    res_char, res_char_next;
  logic          sig_code, sig_code_next;
  logic [6:0]    sig_letter, sig_letter_next;

  logic          line_we, line_re;
  logic [LA-1:0] line_waddr, line_raddr;
  logic [6:0]    line_wdata, line_rdata;
  logic          ring_push, ring_we, ring_re;
  logic [6:0]    ring_wdata, ring_rdata;

  logic is_sig, is_eof_ok, is_bs_ok, is_nl, is_print_ok, copy_issue, ring_full;

  clld_ram #(.WIDTH(7), .DEPTH(clld_pkg::LINE_CAPACITY)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  clld_ram #(.WIDTH(7), .DEPTH(clld_pkg::QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_tail),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  assign is_sig      = (in_key == clld_pkg::KEY_INTR || in_key == clld_pkg::KEY_STOP)
                       && owner_id != 16'd0;
  assign is_eof_ok   = in_key == clld_pkg::KEY_EOF && line_length == '0;
  assign is_bs_ok    = in_key == clld_pkg::KEY_BS && line_length != '0;
  assign is_nl       = in_key == clld_pkg::KEY_NL;
  assign is_print_ok = in_key >= clld_pkg::KEY_SPACE && in_key <= clld_pkg::KEY_TILDE
                       && line_length != LA'(clld_pkg::LINE_CAPACITY - 1);
  assign copy_issue  = idx != line_length;
  assign ring_full   = ring_fill == QF'(clld_pkg::QUEUE_DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      clld_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            clld_pkg::F_KEY: begin
              if (is_sig) begin
                state_next = clld_pkg::S_SIG;
              end else if (is_nl) begin
                state_next = clld_pkg::S_NL;
              end else if (is_eof_ok || is_bs_ok || is_print_ok) begin
                state_next = clld_pkg::S_ONE;
              end
            end
            clld_pkg::F_READ: begin
              state_next = (ring_fill != '0) ? clld_pkg::S_RDW : clld_pkg::S_ONE;
            end
            clld_pkg::F_SET, clld_pkg::F_CLEAR: state_next = clld_pkg::S_IDLE;
          endcase
        end
      end
      clld_pkg::S_ONE: if (out_ready) state_next = clld_pkg::S_IDLE;
      clld_pkg::S_SIG: if (out_ready && step == 2'd3) state_next = clld_pkg::S_IDLE;
      clld_pkg::S_NL: if (out_ready) state_next = clld_pkg::S_COPY;
      clld_pkg::S_COPY: if (!copy_issue && !rd_pend) state_next = clld_pkg::S_ONE;
      clld_pkg::S_RDW: state_next = clld_pkg::S_ONE;
      default: state_next = clld_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    step_next         = step;
    idx_next          = idx;
    rd_pend_next      = rd_pend;
    line_length_next  = line_length;
    ring_head_next    = ring_head;
    ring_tail_next    = ring_tail;
    ring_fill_next    = ring_fill;
    end_of_input_next = end_of_input;
    owner_id_next     = owner_id;
    res_kind_next     = res_kind;
    res_char_next     = res_char;
    sig_code_next     = sig_code;
    sig_letter_next   = sig_letter;
    line_we           = 1'b0;
    line_waddr        = line_length;
    line_wdata        = in_key[6:0];
    line_re           = 1'b0;
    line_raddr        = idx;
    ring_push         = 1'b0;
    ring_wdata        = line_rdata;
    ring_re           = 1'b0;
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    out_word          = '{kind: clld_pkg::K_ECHO, char_out: 7'd0, signal_code: 1'b0,
                          target_owner: 16'd0, last: 1'b0};
    unique case (state)
      clld_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            clld_pkg::F_KEY: begin
              priority if (is_sig) begin
                sig_code_next    = in_key == clld_pkg::KEY_STOP;
                sig_letter_next  = (in_key == clld_pkg::KEY_STOP) ? clld_pkg::CHAR_Z
                                                                  : clld_pkg::CHAR_C;
                step_next        = 2'd0;
                line_length_next = '0;
              end else if (is_eof_ok) begin
                end_of_input_next = 1'b1;
                res_kind_next     = clld_pkg::K_WAKE;
                res_char_next     = 7'd0;
              end else if (is_bs_ok) begin
                line_length_next = line_length - LA'(1);
                res_kind_next    = clld_pkg::K_BS;
                res_char_next    = clld_pkg::CHAR_BS;
              end else if (is_nl) begin
                idx_next     = '0;
                rd_pend_next = 1'b0;
              end else if (is_print_ok) begin
                line_we          = 1'b1;
                line_length_next = line_length + LA'(1);
                res_kind_next    = clld_pkg::K_ECHO;
                res_char_next    = in_key[6:0];
              end else begin
                res_kind_next = res_kind;
              end
            end
            clld_pkg::F_READ: begin
              if (ring_fill != '0) begin
                ring_re        = 1'b1;
                ring_head_next = (ring_head == QA'(clld_pkg::QUEUE_DEPTH - 1))
                                 ? '0 : ring_head + QA'(1);
                ring_fill_next = ring_fill - QF'(1);
              end else begin
                res_kind_next = end_of_input ? clld_pkg::K_EOF : clld_pkg::K_EMPTY;
                res_char_next = 7'd0;
              end
            end
            clld_pkg::F_SET: begin
              owner_id_next     = in_owner;
              line_length_next  = '0;
              ring_head_next    = '0;
              ring_tail_next    = '0;
              ring_fill_next    = '0;
              end_of_input_next = 1'b0;
            end
            clld_pkg::F_CLEAR: begin
              owner_id_next    = 16'd0;
              line_length_next = '0;
            end
          endcase
        end
      end
      clld_pkg::S_ONE: begin
        out_valid         = 1'b1;
        out_word.kind     = res_kind;
        out_word.char_out = res_char;
        out_word.last     = 1'b1;
      end
      clld_pkg::S_SIG: begin
        out_valid = 1'b1;
        unique case (step)
          2'd0: begin
            out_word.kind         = clld_pkg::K_SIGNAL;
            out_word.signal_code  = sig_code;
            out_word.target_owner = owner_id;
          end
          2'd1: out_word.char_out = clld_pkg::CHAR_CARET;
          2'd2: out_word.char_out = sig_letter;
          2'd3: begin
            out_word.char_out = clld_pkg::CHAR_NL;
            out_word.last     = 1'b1;
          end
        endcase
        if (out_ready) begin
          step_next = step + 2'd1;
        end
      end
      clld_pkg::S_NL: begin
        out_valid         = 1'b1;
        out_word.char_out = clld_pkg::CHAR_NL;
      end
      clld_pkg::S_COPY: begin
        line_re      = copy_issue;
        rd_pend_next = copy_issue;
        if (copy_issue) begin
          idx_next = idx + LA'(1);
        end
        if (rd_pend) begin
          ring_push = 1'b1;
        end else if (!copy_issue) begin
          ring_push        = 1'b1;
          ring_wdata       = clld_pkg::CHAR_NL;
          line_length_next = '0;
          res_kind_next    = clld_pkg::K_WAKE;
          res_char_next    = 7'd0;
        end
      end
      clld_pkg::S_RDW: begin
        res_kind_next = clld_pkg::K_DATA;
        res_char_next = ring_rdata;
      end
      default: begin
        res_kind_next = res_kind;
      end
    endcase
    ring_we = ring_push && !ring_full;
    if (ring_we) begin
      ring_tail_next = (ring_tail == QA'(clld_pkg::QUEUE_DEPTH - 1))
                       ? '0 : ring_tail + QA'(1);
      ring_fill_next = ring_fill + QF'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clld_pkg::S_IDLE;
      step         <= 2'd0;
      idx          <= '0;
      rd_pend      <= 1'b0;
      line_length  <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      ring_fill    <= '0;
      end_of_input <= 1'b0;
      owner_id     <= 16'd0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      idx          <= idx_next;
      rd_pend      <= rd_pend_next;
      line_length  <= line_length_next;
      ring_head    <= ring_head_next;
      ring_tail    <= ring_tail_next;
      ring_fill    <= ring_fill_next;
      end_of_input <= end_of_input_next;
      owner_id     <= owner_id_next;
    end
  end

  always_ff @(posedge clk) begin
    res_kind   <= res_kind_next;
    res_char   <= res_char_next;
    sig_code   <= sig_code_next;
    sig_letter <= sig_letter_next;
  end

endmodule

// ===== design/clld_obuf.sv =====
// output register between the sequencer and the result stream
// depends on clld_pkg
module clld_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  clld_pkg::result_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output clld_pkg::result_t out_word
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= in_word;
    end
  end

endmodule

// ===== design/clld_checker.sv =====
// port-level checks for the console line discipline, bound to the top level
// depends on clld_pkg and assert_macros.svh
`include "assert_macros.svh"

module clld_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `CLLD_ASSERT_RST(a_rst_idle, rst |=> !m_axis_tvalid, "output valid after reset")
  `CLLD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled word changed")
  `CLLD_ASSERT(a_one_item, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken mid item")
  `CLLD_ASSERT(a_sig_target, m_axis_tvalid && m_axis_tuser == clld_pkg::K_SIGNAL |-> m_axis_tdata[23:8] != 16'd0 && m_axis_tdata[6:0] == 7'd0, "signal without owner")
  `CLLD_ASSERT(a_nonsig_zero, m_axis_tvalid && m_axis_tuser != clld_pkg::K_SIGNAL |-> m_axis_tdata[23:7] == 17'd0, "stray signal fields")

endmodule

bind console_line_discipline_top clld_checker u_clld_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_console_line_discipline_top.sv =====
// self-checking testbench for console_line_discipline_top: directed table, full line, random keys
// depends on clld_pkg and console_line_discipline_top; predicts result words itself, typed rows give their own
`timescale 1ns / 1ps

module tb_console_line_discipline_top;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 300;
  localparam int ITEM_TARGET  = 310;
  localparam int CALM_FROM    = 298;
  localparam int NUM_ROWS     = 26;

  typedef struct {
    clld_pkg::func_t fn;
    logic [7:0]      key;
    logic [15:0]     own;
    bit              typed;
    clld_pkg::kind_t kind;
    logic [6:0]      ch;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // key_code[7:0], new_owner[23:8]
  logic [1:0]  s_axis_tuser = '0;  // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // char_out[6:0], signal_code[7], target_owner[23:8]
  logic [2:0]  m_axis_tuser;       // kind[2:0]
  logic        m_axis_tlast;

  // predictor state
  logic [6:0]  line_shadow [clld_pkg::LINE_CAPACITY];
  int          line_len = 0;
  logic [6:0]  ring_buf [clld_pkg::QUEUE_DEPTH];
  int          ring_rd = 0;
  int          ring_wr = 0;
  int          ring_cnt = 0;
  bit          eof_seen = 1'b0;
  logic [15:0] fg_owner = '0;

  clld_pkg::result_t awaited_words [$];
  clld_pkg::result_t head_word;

  int  mismatches = 0;
  int  items_sent = 0;
  int  items_acted = 0;
  int  words_checked = 0;
  int  signals_seen = 0;
  int  full_line_drops = 0;
  int  ring_drops = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b1;

  step_t directed_rows [NUM_ROWS] = '{
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b1, clld_pkg::K_EMPTY, 7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_INTR,  16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_EOF,   16'h0000, 1'b1, clld_pkg::K_WAKE,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b1, clld_pkg::K_EOF,   7'h00},
    '{clld_pkg::F_READ,  8'hFF,               16'hFFFF, 1'b1, clld_pkg::K_EOF,   7'h00},
    '{clld_pkg::F_SET,   8'h00,               16'hFFFF, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b1, clld_pkg::K_EMPTY, 7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_SPACE, 16'h0000, 1'b1, clld_pkg::K_ECHO,  7'd32},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_TILDE, 16'h0000, 1'b1, clld_pkg::K_ECHO,  7'd126},
    '{clld_pkg::F_KEY,   8'h7F,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   8'h80,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   8'hFF,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   8'h00,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_EOF,   16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_BS,    16'h0000, 1'b1, clld_pkg::K_BS,
      clld_pkg::CHAR_BS},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_NL,    16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b1, clld_pkg::K_EMPTY, 7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_BS,    16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   8'h41,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_STOP,  16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_INTR,  16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_CLEAR, 8'hFF,               16'hFFFF, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_KEY,   clld_pkg::KEY_NL,    16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00},
    '{clld_pkg::F_READ,  8'h00,               16'h0000, 1'b0, clld_pkg::K_ECHO,  7'h00}
  };

  console_line_discipline_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_word(clld_pkg::kind_t k, logic [6:0] ch, logic sig,
                                    logic [15:0] tgt);
    clld_pkg::result_t w;
    w.kind = k;
    w.char_out = ch;
    w.signal_code = sig;
    w.target_owner = tgt;
    w.last = 1'b0;
    awaited_words.push_back(w);
  endfunction

  function automatic void ring_store(logic [6:0] c);
    if (ring_cnt < clld_pkg::QUEUE_DEPTH) begin
      ring_buf[ring_wr] = c;
      ring_wr = (ring_wr + 1) % clld_pkg::QUEUE_DEPTH;
      ring_cnt++;
    end else begin
      ring_drops++;
    end
  endfunction

  // returns 0 when the item leaves state and output untouched
  function automatic bit compute_console_words(clld_pkg::func_t fn, logic [7:0] key,
                                               logic [15:0] own);
    int  n0;
    int  i;
    bit  acted;
    n0 = awaited_words.size();
    acted = 1'b1;
    case (fn)
      clld_pkg::F_KEY: begin
        if (key == clld_pkg::KEY_INTR || key == clld_pkg::KEY_STOP) begin
          if (fg_owner != '0) begin
            push_word(clld_pkg::K_SIGNAL, 7'h00, key == clld_pkg::KEY_STOP, fg_owner);
            push_word(clld_pkg::K_ECHO, clld_pkg::CHAR_CARET, 1'b0, 16'h0000);
            push_word(clld_pkg::K_ECHO,
                      (key == clld_pkg::KEY_STOP) ? clld_pkg::CHAR_Z : clld_pkg::CHAR_C,
                      1'b0, 16'h0000);
            push_word(clld_pkg::K_ECHO, clld_pkg::CHAR_NL, 1'b0, 16'h0000);
            line_len = 0;
            signals_seen++;
          end else begin
            acted = 1'b0;
          end
        end else if (key == clld_pkg::KEY_EOF) begin
          if (line_len == 0) begin
            eof_seen = 1'b1;
            push_word(clld_pkg::K_WAKE, 7'h00, 1'b0, 16'h0000);
          end else begin
            acted = 1'b0;
          end
        end else if (key == clld_pkg::KEY_BS) begin
          if (line_len != 0) begin
            line_len--;
            push_word(clld_pkg::K_BS, clld_pkg::CHAR_BS, 1'b0, 16'h0000);
          end else begin
            acted = 1'b0;
          end
        end else if (key == clld_pkg::KEY_NL) begin
          push_word(clld_pkg::K_ECHO, clld_pkg::CHAR_NL, 1'b0, 16'h0000);
          for (i = 0; i < line_len; i++) ring_store(line_shadow[i]);
          ring_store(clld_pkg::CHAR_NL);
          line_len = 0;
          push_word(clld_pkg::K_WAKE, 7'h00, 1'b0, 16'h0000);
        end else if (key >= clld_pkg::KEY_SPACE && key <= clld_pkg::KEY_TILDE) begin
          if (line_len + 1 < clld_pkg::LINE_CAPACITY) begin
            line_shadow[line_len] = key[6:0];
            line_len++;
            push_word(clld_pkg::K_ECHO, key[6:0], 1'b0, 16'h0000);
          end else begin
            full_line_drops++;
            acted = 1'b0;
          end
        end else begin
          acted = 1'b0;
        end
      end
      clld_pkg::F_READ: begin
        if (ring_cnt > 0) begin
          push_word(clld_pkg::K_DATA, ring_buf[ring_rd], 1'b0, 16'h0000);
          ring_rd = (ring_rd + 1) % clld_pkg::QUEUE_DEPTH;
          ring_cnt--;
        end else begin
          push_word(eof_seen ? clld_pkg::K_EOF : clld_pkg::K_EMPTY, 7'h00, 1'b0, 16'h0000);
        end
      end
      clld_pkg::F_SET: begin
        fg_owner = own;
        line_len = 0;
        ring_rd = 0;
        ring_wr = 0;
        ring_cnt = 0;
        eof_seen = 1'b0;
      end
      default: begin
        fg_owner = '0;
        line_len = 0;
      end
    endcase
    if (awaited_words.size() > n0) awaited_words[awaited_words.size() - 1].last = 1'b1;
    return acted;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // one word on the input stream; a typed row replaces the predicted word with its own
  task automatic drive_item(clld_pkg::func_t fn, logic [7:0] key, logic [15:0] own,
                            bit typed, clld_pkg::kind_t tk, logic [6:0] tc);
    int n0;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {own, key};
    s_axis_tuser  <= fn;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    n0 = awaited_words.size();
    if (compute_console_words(fn, key, own)) items_acted++;
    if (typed) begin
      while (awaited_words.size() > n0) void'(awaited_words.pop_back());
      push_word(tk, tc, 1'b0, 16'h0000);
      awaited_words[awaited_words.size() - 1].last = 1'b1;
    end
  endtask

  task automatic send(clld_pkg::func_t fn, logic [7:0] key, logic [15:0] own);
    drive_item(fn, key, own, 1'b0, clld_pkg::K_ECHO, 7'h00);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word, kind", 32'(m_axis_tuser), 32'h0);
      end else begin
        head_word = awaited_words.pop_front();
        if (m_axis_tuser !== head_word.kind)
          report_mismatch("kind", 32'(m_axis_tuser), 32'(head_word.kind));
        if (m_axis_tdata[6:0] !== head_word.char_out)
          report_mismatch("char_out", 32'(m_axis_tdata[6:0]), 32'(head_word.char_out));
        if (m_axis_tdata[7] !== head_word.signal_code)
          report_mismatch("signal_code", 32'(m_axis_tdata[7]), 32'(head_word.signal_code));
        if (m_axis_tdata[23:8] !== head_word.target_owner)
          report_mismatch("target_owner", 32'(m_axis_tdata[23:8]),
                          32'(head_word.target_owner));
        if (m_axis_tlast !== head_word.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(head_word.last));
      end
    end
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               quiet_cycles, awaited_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    logic [7:0] key;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++)
      drive_item(directed_rows[i].fn, directed_rows[i].key, directed_rows[i].own,
                 directed_rows[i].typed, directed_rows[i].kind, directed_rows[i].ch);

    // one full line with the last key refused, then read the first bytes back
    send(clld_pkg::F_SET, 8'($urandom), 16'($urandom_range(1, 65535)));
    for (int j = 0; j < clld_pkg::LINE_CAPACITY; j++)
      send(clld_pkg::F_KEY, 8'($urandom_range(32, 126)), 16'($urandom));
    send(clld_pkg::F_KEY, clld_pkg::KEY_NL, 16'($urandom));
    for (int j = 0; j < 2; j++) send(clld_pkg::F_READ, 8'($urandom), 16'($urandom));

    while (items_sent < ITEM_TARGET) begin
      sender_idles    = items_sent < CALM_FROM;
      receiver_stalls = sender_idles;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send(clld_pkg::F_KEY, 8'($urandom_range(32, 126)), 16'($urandom));
      end else if (r < 57) begin
        send(clld_pkg::F_KEY, clld_pkg::KEY_BS, 16'($urandom));
      end else if (r < 65) begin
        send(clld_pkg::F_KEY, clld_pkg::KEY_NL, 16'($urandom));
      end else if (r < 81) begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) send(clld_pkg::F_READ, 8'($urandom), 16'($urandom));
      end else if (r < 84) begin
        send(clld_pkg::F_KEY, clld_pkg::KEY_INTR, 16'($urandom));
      end else if (r < 87) begin
        send(clld_pkg::F_KEY, clld_pkg::KEY_STOP, 16'($urandom));
      end else if (r < 90) begin
        send(clld_pkg::F_KEY, clld_pkg::KEY_EOF, 16'($urandom));
      end else if (r < 94) begin
        send(clld_pkg::F_SET, 8'($urandom),
             ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535)));
      end else if (r < 96) begin
        send(clld_pkg::F_CLEAR, 8'($urandom), 16'($urandom));
      end else begin
        key = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom_range(0, 31));
        send(clld_pkg::F_KEY, key, 16'($urandom));
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d acted, %0d result words checked, %0d signals",
             items_sent, items_acted, words_checked, signals_seen);
    $display("%0d keys refused on a full line, %0d bytes lost to a full ring",
             full_line_drops, ring_drops);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
